// File: hw/rtl/qsrs_pkg.sv
// ----------------------------------------------------------------------------
// qsrs_pkg
// Shared types and constants for the quicksort record sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package qsrs_pkg;

  localparam int Depth    = 32;
  localparam int AddrW    = $clog2(Depth);
  localparam int CountW   = $clog2(Depth + 1);
  localparam int DateW    = 27;
  localparam int CustW    = 37;
  localparam int IdxW     = 6;
  localparam int RecW     = DateW + CustW + IdxW;

  typedef struct packed {
    logic [DateW-1:0] date_key;
    logic [CustW-1:0] customer_key;
    logic             last_item;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]  arrival_index;
    logic [DateW-1:0] out_date;
    logic [CustW-1:0] out_customer;
    logic             last_result;
    logic             overflowed;
  } out_word_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DateW-1:0] date;
    logic [CustW-1:0] cust;
  } rec_t;

endpackage

`default_nettype wire

// File: hw/rtl/quicksort_record_sorter.sv
// ----------------------------------------------------------------------------
// quicksort_record_sorter
// Loads records, sorts them by quicksort (middle pivot, Lomuto partition)
// on the selected key, then emits them in order.
// ----------------------------------------------------------------------------
// Loading: one record per cycle. From the last record in_stall stays high until
// the final sorted word is taken. The sort partitions one range at a time, and
// every comparison goes through the one shared comparator.
// Output: one word at a time; the next is presented only after this one is taken.
// Reset (rst, synchronous): empties the set, clears overflow, selects date key.
`default_nettype none

module quicksort_record_sorter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qsrs_pkg::in_word_t in_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output qsrs_pkg::out_word_t     out_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire logic               cfg_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready
);
  import qsrs_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_POP, S_MID, S_RDM, S_SWM, S_RDI, S_CMP, S_FRD, S_FSW,
    S_PUSHR, S_PUSHL, S_OUTRD, S_OUTLD, S_OUT
  } state_t;

  state_t state;

  rec_t mem [Depth];
  rec_t rd_a, rd_b;

  logic [CountW-1:0] count;
  logic              ovf;
  logic              by_date;

  logic [AddrW-1:0]  stk_lo [Depth];
  logic [AddrW-1:0]  stk_hi [Depth];
  logic [CountW-1:0] sp;
  logic [AddrW-1:0]  sp_top;

  logic [AddrW-1:0]  lo, hi, lim, i, mid;
  logic [AddrW-1:0]  lim_up;
  logic [AddrW:0]    lim_ext, lo_ext;
  logic [CustW-1:0]  pivot;
  logic [AddrW-1:0]  oidx;
  logic [CountW-1:0] oidx_up;

  // memory port control
  logic              we_a, we_b;
  logic [AddrW-1:0]  wa_a, wa_b;
  rec_t              wd_a, wd_b;
  logic [AddrW-1:0]  ra_a, ra_b;

  logic in_acc, out_acc;
  logic [CustW-1:0] key_b;
  logic             is_less;
  logic [AddrW:0]   sum;

  function automatic logic [CustW-1:0] key_of(rec_t r, logic sel);
    return sel ? {{(CustW-DateW){1'b0}}, r.date} : r.cust;
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state != S_LOAD);
  assign cfg_ready = (state == S_LOAD);
  assign sum       = {1'b0, lo} + {1'b0, hi};
  assign key_b     = key_of(rd_b, by_date);
  assign is_less   = key_b < pivot;
  assign lim_up    = lim + AddrW'(1);
  assign lim_ext   = {1'b0, lim} + (AddrW+1)'(1);
  assign lo_ext    = {1'b0, lo} + (AddrW+1)'(1);
  assign sp_top    = sp[AddrW-1:0] - AddrW'(1);
  assign oidx_up   = {1'b0, oidx} + CountW'(1);

  always_ff @(posedge clk) begin
    if (we_a) mem[wa_a] <= wd_a;
    if (we_b) mem[wa_b] <= wd_b;
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  always_comb begin
    we_a = 1'b0; we_b = 1'b0;
    wa_a = lo;   wa_b = mid;
    wd_a = rd_b; wd_b = rd_a;
    ra_a = lo;   ra_b = mid;
    case (state)
      S_LOAD: begin
        we_a = in_acc && (count < CountW'(Depth));
        wa_a = count[AddrW-1:0];
        wd_a = '{idx: IdxW'(count), date: in_data.date_key,
                 cust: in_data.customer_key};
      end
      S_RDM: begin ra_a = lo; ra_b = mid; end
      S_SWM: begin
        we_a = 1'b1; we_b = (mid != lo);
        wa_a = lo; wd_a = rd_b; wa_b = mid; wd_b = rd_a;
      end
      S_RDI: begin ra_a = lim_up; ra_b = i; end
      S_CMP: begin
        we_a = is_less; wa_a = lim_up; wd_a = rd_b;
        we_b = is_less && (lim_up != i); wa_b = i; wd_b = rd_a;
      end
      S_FRD: begin ra_a = lo; ra_b = lim; end
      S_FSW: begin
        we_a = 1'b1; wa_a = lo; wd_a = rd_b;
        we_b = (lim != lo); wa_b = lim; wd_b = rd_a;
      end
      S_OUTRD: begin ra_b = oidx; end
      // prefetch the next word while this one waits
      S_OUT: begin ra_b = oidx + AddrW'(1); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      by_date   <= 1'b1;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) by_date <= cfg_data;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (count < CountW'(Depth)) count <= count + CountW'(1);
            else ovf <= 1'b1;
            if (in_data.last_item) begin
              stk_lo[0] <= '0;
              stk_hi[0] <= (count < CountW'(Depth)) ? count[AddrW-1:0]
                                                     : AddrW'(Depth - 1);
              sp        <= CountW'(1);
              state     <= S_POP;
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            oidx  <= '0;
            state <= S_OUTRD;
          end else begin
            lo    <= stk_lo[sp_top];
            hi    <= stk_hi[sp_top];
            sp    <= sp - CountW'(1);
            state <= S_MID;
          end
        end
        S_MID: begin
          if (lo >= hi) state <= S_POP;
          else begin
            mid   <= sum[AddrW:1];
            state <= S_RDM;
          end
        end
        S_RDM: state <= S_SWM;
        S_SWM: begin
          // rd_b is the middle record, now moved to the front as pivot
          pivot <= key_b;
          lim   <= lo;
          i     <= lo + AddrW'(1);
          state <= S_RDI;
        end
        S_RDI: state <= S_CMP;
        S_CMP: begin
          if (is_less) lim <= lim_up;
          if (i == hi) state <= S_FRD;
          else begin
            i     <= i + AddrW'(1);
            state <= S_RDI;
          end
        end
        S_FRD: state <= S_FSW;
        S_FSW: state <= S_PUSHR;
        // push right range first so the left range is handled first
        S_PUSHR: begin
          if (lim_ext < {1'b0, hi} && sp < CountW'(Depth)) begin
            stk_lo[sp[AddrW-1:0]] <= lim_up;
            stk_hi[sp[AddrW-1:0]] <= hi;
            sp <= sp + CountW'(1);
          end
          state <= S_PUSHL;
        end
        S_PUSHL: begin
          if (lo_ext < {1'b0, lim} && sp < CountW'(Depth)) begin
            stk_lo[sp[AddrW-1:0]] <= lo;
            stk_hi[sp[AddrW-1:0]] <= lim - AddrW'(1);
            sp <= sp + CountW'(1);
          end
          state <= S_POP;
        end
        S_OUTRD: state <= S_OUTLD;
        S_OUTLD: begin
          out_data  <= '{arrival_index: rd_b.idx, out_date: rd_b.date,
                         out_customer: rd_b.cust,
                         last_result: (oidx_up == count), overflowed: ovf};
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (out_data.last_result) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              oidx  <= oidx + AddrW'(1);
              state <= S_OUTLD;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Record sorter check: loads record sets, predicts the quicksort order
// (middle pivot, Lomuto partition on strict less-than) and compares every
// emitted word with the prediction.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qsrs_pkg::*;

  localparam int CycleLimit = 3000000;

  class sorted_record_board;
    rec_t      held[$];
    bit        dropped;
    bit        by_date = 1'b1;
    out_word_t pending[$];
    int        errors;
    int        sets_done;
    int        checked;

    function bit key_less(rec_t a, rec_t b);
      if (by_date) return a.date < b.date;
      return a.cust < b.cust;
    endfunction

    function void order_set();
      int   lo_q[$];
      int   hi_q[$];
      int   lo, hi, lim, mid, i;
      rec_t t;
      if (held.size() < 2) return;
      lo_q.push_back(0);
      hi_q.push_back(held.size() - 1);
      while (lo_q.size() > 0) begin
        lo = lo_q.pop_back();
        hi = hi_q.pop_back();
        if (lo >= hi) continue;
        mid = (lo + hi) / 2;
        t = held[lo]; held[lo] = held[mid]; held[mid] = t;
        lim = lo;
        for (i = lo + 1; i <= hi; i++) begin
          if (key_less(held[i], held[lo])) begin
            lim++;
            t = held[lim]; held[lim] = held[i]; held[i] = t;
          end
        end
        t = held[lo]; held[lo] = held[lim]; held[lim] = t;
        // push right range first so the left one is sorted first
        if (lim + 1 < hi && lo_q.size() < Depth) begin
          lo_q.push_back(lim + 1); hi_q.push_back(hi);
        end
        if (lo < lim - 1 && lo_q.size() < Depth) begin
          lo_q.push_back(lo); hi_q.push_back(lim - 1);
        end
      end
    endfunction

    function void note_record(in_word_t w);
      rec_t      r;
      out_word_t o;
      if (held.size() < Depth) begin
        r.idx  = IdxW'(held.size());
        r.date = w.date_key;
        r.cust = w.customer_key;
        held.push_back(r);
      end else begin
        dropped = 1'b1;
      end
      if (!w.last_item) return;
      order_set();
      foreach (held[k]) begin
        o.arrival_index = held[k].idx;
        o.out_date      = held[k].date;
        o.out_customer  = held[k].cust;
        o.last_result   = (k == held.size() - 1);
        o.overflowed    = dropped;
        pending.push_back(o);
      end
      held.delete();
      dropped = 1'b0;
      sets_done++;
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
        return;
      end
      exp = pending.pop_front();
      if (got.arrival_index !== exp.arrival_index)
        $display("%0t: arrival_index exp %0d got %0d", $time, exp.arrival_index,
                 got.arrival_index);
      if (got.out_date !== exp.out_date)
        $display("%0t: out_date exp %0d got %0d", $time, exp.out_date, got.out_date);
      if (got.out_customer !== exp.out_customer)
        $display("%0t: out_customer exp %0d got %0d", $time, exp.out_customer,
                 got.out_customer);
      if (got.last_result !== exp.last_result)
        $display("%0t: last_result exp %0b got %0b", $time, exp.last_result,
                 got.last_result);
      if (got.overflowed !== exp.overflowed)
        $display("%0t: overflowed exp %0b got %0b", $time, exp.overflowed,
                 got.overflowed);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic      clk;
  logic      rst;
  in_word_t  in_data;
  logic      in_valid;
  logic      in_stall;
  out_word_t out_data;
  logic      out_valid;
  logic      out_stall;
  logic      cfg_data;
  logic      cfg_valid;
  logic      cfg_ready;

  sorted_record_board board;
  int  cycles;
  bit  hold_long;

  quicksort_record_sorter dut (
    .clk(clk), .rst(rst),
    .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int wait_n;
    out_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        hold_long = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && !hold_long) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_word(out_data);
  end

  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_record(w);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.by_date = v;
  endtask

  function automatic in_word_t rand_record(bit last, int style);
    in_word_t w;
    case (style)
      0: begin
        w.date_key     = DateW'($urandom_range(0, 3));
        w.customer_key = CustW'($urandom_range(0, 3));
      end
      1: begin
        w.date_key     = DateW'($urandom_range(0, 99991231));
        w.customer_key = CustW'({$urandom, $urandom} % 64'd100000000000);
      end
      default: begin
        w.date_key     = DateW'($urandom);
        w.customer_key = CustW'({$urandom, $urandom});
      end
    endcase
    w.last_item = last;
    return w;
  endfunction

  task automatic send_set(int n, int style, bit busy);
    for (int i = 0; i < n; i++)
      send_word(rand_record(i == n - 1, style),
                busy ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0));
  endtask

  initial begin
    in_word_t w;
    int       n;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes on both keys, single record, full and overflow
    w = '0; w.last_item = 1'b1;
    send_word(w, 0);
    w.date_key = '1; w.customer_key = '1; w.last_item = 1'b0;
    send_word(w, 0);
    w = '0; send_word(w, 1);
    w.date_key = DateW'(99991231); w.customer_key = CustW'(64'd99999999999);
    send_word(w, 0);
    w = '0; w.date_key = 5; w.customer_key = 5; w.last_item = 1'b1;
    send_word(w, 0);
    drain_all();
    write_mode(1'b0);
    w = '0; w.customer_key = '1; send_word(w, 0);
    w.customer_key = 0; w.date_key = '1; send_word(w, 0);
    w.customer_key = CustW'(64'd99999999999); w.last_item = 1'b1; send_word(w, 0);
    drain_all();
    write_mode(1'b1);
    send_set(Depth, 0, 1'b1);
    send_set(Depth + 3, 2, 1'b1);
    drain_all();

    // long receiver hold-off while the sender keeps offering sets
    hold_long = 1'b1;
    send_set(Depth, 1, 1'b1);
    send_set(8, 1, 1'b1);
    drain_all();

    // random sets, mostly small, a few full or overflowing
    while (board.sets_done < 30) begin
      case ($urandom_range(0, 9))
        0: n = Depth + $urandom_range(1, 4);
        1: n = Depth;
        default: n = $urandom_range(1, 10);
      endcase
      send_set(n, $urandom_range(0, 2), $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        drain_all();
        write_mode(1'($urandom_range(0, 1)));
      end
    end
    drain_all();
    write_mode(1'b1);

    $display("covered %0d sets, %0d words checked, both sort keys, overflow and stalls",
             board.sets_done, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: quicksort_record_sorter.f
hw/rtl/qsrs_pkg.sv
hw/rtl/quicksort_record_sorter.sv
tb/tb_top.sv
